// File: rtl/cosine_nearest_match_core_defines.svh
// Assertion macros shared by the cosine nearest match RTL.
// Needs a clock named clk and an active high reset named rst in scope.
`ifndef COSINE_NEAREST_MATCH_CORE_DEFINES_SVH
`define COSINE_NEAREST_MATCH_CORE_DEFINES_SVH

// same-cycle implication
`define CNM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cnm assertion failed");

// next-cycle implication
`define CNM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cnm assertion failed");

`endif

// File: rtl/cnm_pkg.sv
// Shared types, sizes and codes of the cosine nearest match block.
// No dependencies.
package cnm_pkg;

  localparam int ENTRIES    = 256;
  localparam int DIM        = 128;
  localparam int NORM_SHIFT = 22;
  localparam int NUM_SHIFT  = 37;
  localparam int TINY_LIMIT = 115;

  localparam int RA_W    = $clog2(ENTRIES);
  localparam int RC_W    = $clog2(ENTRIES + 1);
  localparam int QA_W    = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int EC_W    = $clog2(DIM + 1);
  localparam int VA_W    = $clog2(ENTRIES * DIM);
  localparam int NORM_W  = 31 + $clog2(DIM);
  localparam int DOT_W   = NORM_W + 1;
  localparam int SQ_IN_W = NORM_W + NORM_SHIFT;
  localparam int RT_W    = (SQ_IN_W + 1) / 2;
  localparam int D_W     = 2 * RT_W;
  localparam int Q_W     = 17;
  localparam int K_W     = $clog2(Q_W);
  localparam int NUM_W   = NORM_W + NUM_SHIFT;
  localparam int DIV_W   = (NUM_W > D_W + Q_W - 1) ? NUM_W : D_W + Q_W - 1;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_STORED   = 3'd0,
    ST_FULL     = 3'd1,
    ST_TOO_LONG = 3'd2,
    ST_ANSWER   = 3'd3,
    ST_CLEARED  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    T_IDLE, T_START, T_WAIT, T_LABEL, T_EMIT
  } top_state_t;

  typedef enum logic [2:0] {
    S_IDLE, S_LEN, S_MAC, S_CHK, S_SQRT, S_MUL, S_DIV, S_DONE
  } sim_state_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [15:0]        label;
    logic signed [15:0] element;
    logic               last;
  } req_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               matched;
    logic [15:0]        match_label;
    logic signed [15:0] similarity;
  } rsp_item_t;

  typedef struct packed {
    logic            start;
    logic [RA_W-1:0] rec;
    logic [EC_W-1:0] qlen;
  } sim_req_t;

  typedef struct packed {
    logic               done;
    logic signed [15:0] value;
  } sim_res_t;

endpackage

// File: rtl/cnm_ram.sv
// Generic simple dual port RAM: one write port, one registered read port.
// No dependencies.
module cnm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/cnm_isqrt.sv
// Iterative floor square root, one result bit per cycle.
// Uses cnm_pkg for widths.
module cnm_isqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [cnm_pkg::SQ_IN_W-1:0] v,
  output logic                       busy,
  output logic [cnm_pkg::RT_W-1:0]   root
);
  import cnm_pkg::*;

  localparam int TOP = 2 * (RT_W - 1);

  logic [SQ_IN_W-1:0] rem_v;
  logic [SQ_IN_W-1:0] res;
  logic [SQ_IN_W-1:0] bit_r;
  logic [SQ_IN_W:0]   trial;

  assign trial = {1'b0, res} + {1'b0, bit_r};
  assign root  = res[RT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && bit_r == SQ_IN_W'(1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_v <= v;
      res   <= '0;
      bit_r <= SQ_IN_W'(1) << TOP;
    end else if (busy) begin
      if ({1'b0, rem_v} >= trial) begin
        rem_v <= rem_v - trial[SQ_IN_W-1:0];
        res   <= (res >> 1) + bit_r;
      end else begin
        res <= res >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end
endmodule

// File: rtl/cnm_sim.sv
// Similarity of the query buffer against one stored record: dot product and
// norms, zero checks, two square roots, one multiply, bit-serial divide.
// Uses cnm_pkg and cnm_isqrt.
module cnm_sim (
  input  logic                     clk,
  input  logic                     rst,
  input  cnm_pkg::sim_req_t        req,
  output cnm_pkg::sim_res_t        res,
  output logic [cnm_pkg::RA_W-1:0] len_raddr,
  input  logic [cnm_pkg::EC_W-1:0] len_rdata,
  output logic [cnm_pkg::VA_W-1:0] vec_raddr,
  input  logic signed [15:0]       vec_rdata,
  output logic [cnm_pkg::QA_W-1:0] qb_raddr,
  input  logic signed [15:0]       qb_rdata
);
  import cnm_pkg::*;

  sim_state_t state, state_next;

  logic [RA_W-1:0]          rec;
  logic [EC_W-1:0]          qlen;
  logic [EC_W-1:0]          icnt;
  logic                     issue;
  logic                     pv1, pv2;
  logic signed [31:0]       prod_dot;
  logic [30:0]              prod_q, prod_s;
  logic signed [DOT_W-1:0]  dot;
  logic [NORM_W-1:0]        nq, ns;
  logic [NORM_W-1:0]        adot;
  logic                     neg;
  logic [13:0]              tiny_prod;
  logic                     is_zero;
  logic                     sq_start;
  logic                     busy_a, busy_b;
  logic [RT_W-1:0]          sa, sb;
  logic [D_W-1:0]           prod_d;
  logic [DIV_W-1:0]         rem, dsh;
  logic [Q_W-1:0]           quo;
  logic [K_W-1:0]           k;
  logic                     fits;
  logic signed [15:0]       value;

  assign issue     = (state == S_MAC) && (icnt < qlen);
  assign len_raddr = req.start ? req.rec : rec;
  assign qb_raddr  = icnt[QA_W-1:0];
  assign vec_raddr = VA_W'(rec) * VA_W'(DIM) + VA_W'(icnt[QA_W-1:0]);

  // only meaningful when both norms are at most the limit
  assign tiny_prod = 14'(nq[6:0]) * 14'(ns[6:0]);
  assign is_zero   = (nq == '0) || (ns == '0) ||
                     (nq <= NORM_W'(TINY_LIMIT) && ns <= NORM_W'(TINY_LIMIT) &&
                      tiny_prod <= 14'(TINY_LIMIT));
  assign sq_start  = (state == S_CHK) && !is_zero;
  assign prod_d    = sa * sb;
  assign fits      = rem >= dsh;

  assign res.done  = (state == S_DONE);
  assign res.value = value;

  cnm_isqrt u_sqrt_q (
    .clk(clk), .rst(rst), .start(sq_start),
    .v(SQ_IN_W'(nq) << NORM_SHIFT), .busy(busy_a), .root(sa)
  );

  cnm_isqrt u_sqrt_s (
    .clk(clk), .rst(rst), .start(sq_start),
    .v(SQ_IN_W'(ns) << NORM_SHIFT), .busy(busy_b), .root(sb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (req.start) state_next = S_LEN;
      S_LEN:  state_next = (len_rdata == qlen) ? S_MAC : S_DONE;
      S_MAC:  if (!issue && !pv1 && !pv2) state_next = S_CHK;
      S_CHK:  state_next = is_zero ? S_DONE : S_SQRT;
      S_SQRT: if (!busy_a && !busy_b) state_next = S_MUL;
      S_MUL:  state_next = S_DIV;
      S_DIV:  if (k == '0) state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv1 <= 1'b0;
      pv2 <= 1'b0;
    end else begin
      pv1 <= issue;
      pv2 <= pv1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.start) begin
      rec  <= req.rec;
      qlen <= req.qlen;
    end
    if (state == S_LEN) begin
      icnt  <= '0;
      dot   <= '0;
      nq    <= '0;
      ns    <= '0;
      value <= '0;
    end
    if (issue) begin
      icnt <= icnt + 1'b1;
    end
    if (pv1) begin
      prod_dot <= qb_rdata * vec_rdata;
      prod_q   <= 31'(qb_rdata * qb_rdata);
      prod_s   <= 31'(vec_rdata * vec_rdata);
    end
    if (pv2) begin
      dot <= dot + DOT_W'(prod_dot);
      nq  <= nq + NORM_W'(prod_q);
      ns  <= ns + NORM_W'(prod_s);
    end
    if (state == S_CHK) begin
      neg  <= dot < 0;
      adot <= NORM_W'((dot < 0) ? -dot : dot);
      if (is_zero) begin
        value <= '0;
      end
    end
    if (state == S_MUL) begin
      rem <= DIV_W'(adot) << NUM_SHIFT;
      dsh <= DIV_W'(prod_d) << (Q_W - 1);
      quo <= '0;
      k   <= K_W'(Q_W - 1);
    end
    if (state == S_DIV) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      dsh <= dsh >> 1;
      quo <= {quo[Q_W-2:0], fits};
      k   <= k - 1'b1;
      if (k == '0) begin
        // quotient with the final bit, saturated to Q1.15
        if (neg) begin
          value <= ({quo[Q_W-2:0], fits} > Q_W'(32768)) ? -16'sd32768 :
                   -$signed({quo[14:0], fits});
        end else begin
          value <= ({quo[Q_W-2:0], fits} > Q_W'(32767)) ? 16'sd32767 :
                   $signed({quo[14:0], fits});
        end
      end
    end
  end
endmodule

// File: rtl/cosine_nearest_match_core.sv
// Cosine nearest match: a store of up to ENTRIES labelled vectors of up to
// DIM Q1.15 elements. Element items are taken one per cycle unless an
// answer waits on rsp_ready; clear and add answers follow in the cycle
// after acceptance. The last item of a query scans every stored record in
// turn through one similarity unit: a record whose length differs from the
// query is skipped; a matching one streams n elements from the vector
// memory, then runs 30-step square roots and a 17-step divide. No item is
// taken during the scan. The threshold may be written only while idle.
module cosine_nearest_match_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  cnm_pkg::req_item_t req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output cnm_pkg::rsp_item_t rsp,
  input  logic               cfg_wen,
  input  logic [15:0]        cfg_wdata
);
  import cnm_pkg::*;
  `include "cosine_nearest_match_core_defines.svh"

  top_state_t state, state_next;

  logic [RC_W-1:0]    rec_count;
  logic [EC_W-1:0]    elem_count;
  logic [EC_W-1:0]    qlen;
  logic [RC_W-1:0]    scan_rec;
  logic signed [15:0] best;
  logic [RA_W-1:0]    best_rec;
  logic signed [15:0] threshold;

  logic acc, room, full, is_add, is_query;
  logic start_scan;
  logic rsp_set;

  sim_req_t sim_req;
  sim_res_t sim_res;

  logic [RA_W-1:0]    len_raddr;
  logic [EC_W-1:0]    len_rdata;
  logic [VA_W-1:0]    vec_raddr, vec_waddr;
  logic signed [15:0] vec_rdata, qb_rdata;
  logic [QA_W-1:0]    qb_raddr;
  logic [15:0]        label_rdata;
  logic               vec_we, qb_we, rec_we;

  assign req_ready = (state == T_IDLE) && (!rsp_valid || rsp_ready);
  assign acc       = req_valid && req_ready;
  assign room      = elem_count < EC_W'(DIM);
  assign full      = rec_count >= RC_W'(ENTRIES);
  assign is_add    = req.kind == KIND_ADD;
  assign is_query  = req.kind == KIND_QUERY;

  assign start_scan = acc && is_query && room && req.last && rec_count != '0;

  // every accepted item that answers at once, or the end of a scan
  assign rsp_set = (acc && req.kind != KIND_NONE &&
                    (req.kind == KIND_CLEAR || !room ||
                     (req.last && (is_add || rec_count == '0)))) ||
                   (state == T_EMIT);

  assign vec_we    = acc && is_add && room && !full;
  assign rec_we    = vec_we && req.last;
  assign qb_we     = acc && is_query && room;
  assign vec_waddr = VA_W'(rec_count[RA_W-1:0]) * VA_W'(DIM) +
                     VA_W'(elem_count[QA_W-1:0]);

  assign sim_req.start = (state == T_START);
  assign sim_req.rec   = scan_rec[RA_W-1:0];
  assign sim_req.qlen  = qlen;

  cnm_ram #(.WIDTH(16), .DEPTH(ENTRIES * DIM)) u_vec_ram (
    .clk(clk), .we(vec_we), .waddr(vec_waddr), .wdata(req.element),
    .raddr(vec_raddr), .rdata(vec_rdata)
  );

  cnm_ram #(.WIDTH(16), .DEPTH(DIM)) u_qbuf_ram (
    .clk(clk), .we(qb_we), .waddr(elem_count[QA_W-1:0]), .wdata(req.element),
    .raddr(qb_raddr), .rdata(qb_rdata)
  );

  cnm_ram #(.WIDTH(16), .DEPTH(ENTRIES)) u_label_ram (
    .clk(clk), .we(rec_we), .waddr(rec_count[RA_W-1:0]), .wdata(req.label),
    .raddr(best_rec), .rdata(label_rdata)
  );

  cnm_ram #(.WIDTH(EC_W), .DEPTH(ENTRIES)) u_len_ram (
    .clk(clk), .we(rec_we), .waddr(rec_count[RA_W-1:0]),
    .wdata(elem_count + 1'b1), .raddr(len_raddr), .rdata(len_rdata)
  );

  cnm_sim u_sim (
    .clk(clk), .rst(rst), .req(sim_req), .res(sim_res),
    .len_raddr(len_raddr), .len_rdata(len_rdata),
    .vec_raddr(vec_raddr), .vec_rdata(vec_rdata),
    .qb_raddr(qb_raddr), .qb_rdata(qb_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      T_IDLE:  if (start_scan) state_next = T_START;
      T_START: state_next = T_WAIT;
      T_WAIT: begin
        if (sim_res.done) begin
          state_next = (scan_rec + 1'b1 == rec_count) ? T_LABEL : T_START;
        end
      end
      T_LABEL: state_next = T_EMIT;
      T_EMIT:  state_next = T_IDLE;
      default: state_next = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_count  <= '0;
      elem_count <= '0;
      rsp_valid  <= 1'b0;
      threshold  <= 16'sd16384;
    end else begin
      if (rsp_set) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_wen) begin
        threshold <= cfg_wdata;
      end
      if (acc && req.kind != KIND_NONE) begin
        rsp.matched     <= 1'b0;
        rsp.match_label <= '0;
        rsp.similarity  <= '0;
        if (req.kind == KIND_CLEAR) begin
          rec_count  <= '0;
          elem_count <= '0;
          rsp.status <= ST_CLEARED;
        end else if (!room) begin
          if (req.last) begin
            elem_count <= '0;
          end
          rsp.status <= ST_TOO_LONG;
        end else if (!req.last) begin
          elem_count <= elem_count + 1'b1;
        end else begin
          elem_count <= '0;
          if (is_add) begin
            if (full) begin
              rsp.status <= ST_FULL;
            end else begin
              rec_count  <= rec_count + 1'b1;
              rsp.status <= ST_STORED;
            end
          end else begin
            qlen <= elem_count + 1'b1;
            // empty store answers at once with no match
            if (rec_count == '0) begin
              rsp.status <= ST_ANSWER;
            end
          end
        end
      end
      if (state == T_EMIT) begin
        rsp.status      <= ST_ANSWER;
        rsp.matched     <= best >= threshold;
        rsp.match_label <= (best >= threshold) ? label_rdata : 16'd0;
        rsp.similarity  <= (best >= threshold) ? best : 16'sd0;
      end
    end
  end

  // running best; the earliest record wins a tie
  always_ff @(posedge clk) begin
    if (start_scan) begin
      scan_rec <= '0;
    end
    if (state == T_WAIT && sim_res.done) begin
      scan_rec <= scan_rec + 1'b1;
      if (scan_rec == '0 || sim_res.value > best) begin
        best     <= sim_res.value;
        best_rec <= scan_rec[RA_W-1:0];
      end
    end
  end

  `CNM_ASSERT_IMP(a_no_accept_in_scan, state != T_IDLE, !req_ready)
  `CNM_ASSERT_IMP(a_rec_count_range, 1'b1, rec_count <= RC_W'(ENTRIES))
  `CNM_ASSERT_IMP(a_elem_count_range, 1'b1, elem_count <= EC_W'(DIM))
  `CNM_ASSERT_IMP(a_emit_slot_free, state == T_EMIT, !rsp_valid)
  `CNM_ASSERT_IMP(a_sim_done_in_wait, sim_res.done, state == T_WAIT)
endmodule

// File: tb/sv/cosine_nearest_match_core_tb.sv
// Self-checking testbench for cosine_nearest_match_core: directed and random
// vectors, a fixed-point predictor of the store and search, and random stalls.
// Depends on cnm_pkg and the core RTL only.
module cosine_nearest_match_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cnm_pkg::*;

  localparam int IDLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 50;

  class cnm_scoreboard;
    int errors;
    rsp_item_t expected[$];
    logic signed [15:0] vstore [0:ENTRIES*DIM-1];
    logic [15:0] labels [0:ENTRIES-1];
    int lengths [0:ENTRIES-1];
    logic signed [15:0] qbuf [0:DIM-1];
    int rec_count;
    int elem_count;
    int threshold;

    function new();
      errors = 0;
      rec_count = 0;
      elem_count = 0;
      threshold = 16384;
    endfunction

    task report(string s);
      $display("mismatch @%0t: %s", $realtime, s);
      errors++;
    endtask

    function longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned res, bit_v;
      res = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > v) bit_v >>= 2;
      while (bit_v != 0) begin
        if (v >= res + bit_v) begin
          v -= res + bit_v;
          res = (res >> 1) + bit_v;
        end else begin
          res >>= 1;
        end
        bit_v >>= 2;
      end
      return res;
    endfunction

    function int cosine(int rec, int qlen);
      longint dot;
      longint unsigned nq, ns, sa, sb;
      logic [127:0] d, num, q;
      int a, b;
      dot = 0; nq = 0; ns = 0;
      if (qlen != lengths[rec] || qlen == 0) return 0;
      for (int i = 0; i < qlen; i++) begin
        a = qbuf[i];
        b = vstore[rec*DIM + i];
        dot += a * b;
        nq += longint'(a * a);
        ns += longint'(b * b);
      end
      // norm product below 1e-8
      if (nq <= TINY_LIMIT && ns <= TINY_LIMIT && nq * ns <= TINY_LIMIT) return 0;
      sa = floor_sqrt(nq << NORM_SHIFT);
      sb = floor_sqrt(ns << NORM_SHIFT);
      d = 128'(sa) * 128'(sb);
      if (d == 0) return 0;
      num = 128'(dot < 0 ? -dot : dot) << NUM_SHIFT;
      q = num / d;
      if (dot < 0) return (q > 32768) ? -32768 : -int'(q);
      return (q > 32767) ? 32767 : int'(q);
    endfunction

    function void note_request(req_item_t x);
      rsp_item_t r;
      int n, best, best_rec, s;
      r = '0;
      if (x.kind == KIND_NONE) return;
      if (x.kind == KIND_CLEAR) begin
        rec_count = 0;
        elem_count = 0;
        r.status = ST_CLEARED;
        expected.insert(expected.size(), r);
        return;
      end
      if (elem_count >= DIM) begin
        if (x.last) elem_count = 0;
        r.status = ST_TOO_LONG;
        expected.insert(expected.size(), r);
        return;
      end
      if (x.kind == KIND_ADD) begin
        if (rec_count < ENTRIES) vstore[rec_count*DIM + elem_count] = x.element;
      end else begin
        qbuf[elem_count] = x.element;
      end
      elem_count++;
      if (!x.last) return;
      n = elem_count;
      elem_count = 0;
      if (x.kind == KIND_ADD) begin
        if (rec_count >= ENTRIES) begin
          r.status = ST_FULL;
        end else begin
          labels[rec_count] = x.label;
          lengths[rec_count] = n;
          rec_count++;
          r.status = ST_STORED;
        end
        expected.insert(expected.size(), r);
        return;
      end
      r.status = ST_ANSWER;
      if (rec_count > 0) begin
        best_rec = 0;
        best = cosine(0, n);
        for (int rec = 1; rec < rec_count; rec++) begin
          s = cosine(rec, n);
          if (s > best) begin
            best = s;
            best_rec = rec;
          end
        end
        if (best >= threshold) begin
          r.matched = 1'b1;
          r.match_label = labels[best_rec];
          r.similarity = 16'(best);
        end
      end
      expected.insert(expected.size(), r);
    endfunction

    task check_result(rsp_item_t got);
      rsp_item_t e;
      if (expected.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      e = expected.pop_front();
      if (got.status !== e.status)
        report($sformatf("status %0d, want %0d", got.status, e.status));
      if (got.matched !== e.matched)
        report($sformatf("matched %0d, want %0d", got.matched, e.matched));
      if (got.match_label !== e.match_label)
        report($sformatf("label %0h, want %0h", got.match_label, e.match_label));
      if (got.similarity !== e.similarity)
        report($sformatf("similarity %0d, want %0d", got.similarity, e.similarity));
    endtask
  endclass

  logic clk, rst;
  logic req_valid, req_ready, rsp_valid, rsp_ready, cfg_wen;
  req_item_t req;
  rsp_item_t rsp;
  logic [15:0] cfg_wdata;

  cnm_scoreboard sb;
  int idle_cycles;
  int items_sent;
  int burst_left;
  int stall_mode;
  int stall_timer;
  logic signed [15:0] lib [0:63][0:DIM-1];
  int lib_len [0:63];
  int lib_count;

  cosine_nearest_match_core dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) sb.check_result(rsp);
  end

  // receiver stall pattern: changes character whenever its random timer runs out
  always @(posedge clk) begin
    if (stall_timer == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_timer <= $urandom_range(50, 300);
    end else begin
      stall_timer <= stall_timer - 1;
    end
    case (stall_mode)
      0: rsp_ready <= 1'b1;
      1: rsp_ready <= (stall_timer % 4) != 0;
      2: rsp_ready <= $urandom_range(0, 1);
      default: rsp_ready <= (stall_timer % 24) >= 20;
    endcase
  end

  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send(logic [1:0] kind, logic [15:0] label, logic signed [15:0] elem,
                      logic last);
    req_item_t x;
    int gap;
    x.kind = kind;
    x.label = label;
    x.element = elem;
    x.last = last;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 7);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 12);
    end
    burst_left--;
    req_valid <= 1'b1;
    req <= x;
    do @(posedge clk); while (!req_ready);
    sb.note_request(x);
    if (kind != KIND_NONE) items_sent++;
  endtask

  task automatic send_vec(logic [1:0] kind, logic [15:0] label, int slot, int len);
    for (int i = 0; i < len; i++)
      send(kind, label, lib[slot][i], i == len - 1);
  endtask

  function automatic logic signed [15:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 15)) - 16'sd8;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic fill_slot(int slot, int len);
    lib_len[slot] = len;
    for (int i = 0; i < len; i++) lib[slot][i] = rand_elem();
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (sb.expected.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_threshold(logic [15:0] v);
    drain();
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    sb.threshold = int'($signed(v));
  endtask

  task automatic random_op();
    int op, src, len, k;
    op = $urandom_range(0, 99);
    if (op < 40) begin
      src = lib_count % 64;
      fill_slot(src, $urandom_range(0, 7) == 0 ? $urandom_range(9, 24) : $urandom_range(1, 8));
      send_vec(KIND_ADD, 16'($urandom), src, lib_len[src]);
      lib_count++;
    end else if (op < 75) begin
      // query near a stored vector: copy, negate, scale or nudge elements
      src = 63;
      k = $urandom_range(0, (lib_count < 64 ? lib_count : 64) - 1);
      lib_len[src] = lib_len[k];
      for (int i = 0; i < lib_len[k]; i++) begin
        case ($urandom_range(0, 4))
          0: lib[src][i] = -lib[k][i];
          1: lib[src][i] = lib[k][i] >>> 1;
          2: lib[src][i] = lib[k][i] + 16'($urandom_range(0, 4000)) - 16'sd2000;
          default: lib[src][i] = lib[k][i];
        endcase
      end
      if ($urandom_range(0, 5) == 0) fill_slot(src, $urandom_range(1, 8));
      send_vec(KIND_QUERY, 16'($urandom), src, lib_len[src]);
    end else if (op < 85) begin
      send(KIND_CLEAR, 16'($urandom), 16'($urandom), 1'($urandom));
    end else if (op < 90) begin
      send(KIND_NONE, 16'($urandom), 16'($urandom), 1'($urandom));
    end else if (op < 95) begin
      // kinds mixed inside a vector that ends as a query
      len = $urandom_range(2, 6);
      for (int i = 0; i < len; i++)
        send(i == len - 1 ? KIND_QUERY : 2'($urandom_range(0, 1)), 16'($urandom),
             rand_elem(), i == len - 1);
    end else begin
      len = $urandom_range(1, 4);
      for (int i = 0; i < len; i++)
        send(KIND_QUERY, 16'($urandom), 16'($urandom_range(0, 2)) - 16'sd1,
             i == len - 1);
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    rsp_ready = 1'b0;
    stall_mode = 0;
    stall_timer = 0;
    idle_cycles = 0;
    items_sent = 0;
    burst_left = 0;
    lib_count = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty store, ties, opposite vectors, zero norm, overlong vectors
    send(KIND_QUERY, 16'h0, 16'sh7FFF, 1'b1);
    lib[0][0] = 16'sh7FFF; lib[0][1] = 16'sh0000; lib_len[0] = 2;
    lib[1][0] = 16'sh8000; lib[1][1] = 16'sh0000; lib_len[1] = 2;
    lib[2][0] = 16'sh0000; lib[2][1] = 16'sh7FFF; lib_len[2] = 2;
    lib[3][0] = 16'sh0000; lib[3][1] = 16'sh0000; lib_len[3] = 2;
    lib_count = 4;
    send_vec(KIND_ADD, 16'hFFFF, 0, 2);
    send_vec(KIND_ADD, 16'h0000, 1, 2);
    send_vec(KIND_ADD, 16'h0001, 0, 2);
    send_vec(KIND_ADD, 16'h0005, 3, 2);
    send_vec(KIND_QUERY, 16'h0, 0, 2);
    send_vec(KIND_QUERY, 16'h0, 1, 2);
    send_vec(KIND_QUERY, 16'h0, 3, 2);
    send(KIND_NONE, 16'hFFFF, 16'sh7FFF, 1'b1);
    // fills the whole query buffer, then one element too many
    for (int i = 0; i <= DIM; i++) send(KIND_QUERY, 16'h1234, rand_elem(), i == DIM);

    set_threshold(16'h8000);
    send_vec(KIND_QUERY, 16'h0, 2, 2);
    send(KIND_CLEAR, 16'h0, 16'sh0, 1'b0);
    // fill the store with one-element records, then overflow it
    for (int r = 0; r <= ENTRIES; r++) send(KIND_ADD, 16'($urandom), rand_elem(), 1'b1);
    send(KIND_QUERY, 16'h0, 16'sh4000, 1'b1);
    send(KIND_CLEAR, 16'hFFFF, 16'shFFFF, 1'b1);

    set_threshold(16'h7FFF);
    while (items_sent < 400 + RANDOM_ITEMS) begin
      random_op();
      if (items_sent % 20 < 3) begin
        case ($urandom_range(0, 3))
          0: set_threshold(16'h0000);
          1: set_threshold(16'h4000);
          2: set_threshold(16'h8000);
          default: set_threshold(16'($urandom));
        endcase
      end
    end

    drain();
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
